@@ rtl/core/sm3_pkg.sv @@
// shared constants, types and helper functions for the sm3 hash core
`timescale 1ns / 1ps

package sm3_pkg;

    localparam int WordW   = 32;
    localparam int BlkWords = 16;
    localparam int Rounds  = 64;
    localparam int DigWords = 8;
    localparam int TdataW  = 40;

    localparam logic [WordW-1:0] T_LOW    = 32'h79CC4519;
    localparam logic [WordW-1:0] T_HIGH   = 32'h7A879D8A;
    // high round constant pre-rotated by 16 for the first round that uses it
    localparam logic [WordW-1:0] T_HIGH_R = 32'h9D8A7A87;
    localparam logic [WordW-1:0] PAD_WORD = 32'h80000000;

    typedef logic [WordW-1:0] word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_OUT
    } state_t;

    function automatic word_t rotl(input word_t x, input int unsigned n);
        int unsigned m;
        m = n % 32;
        if (m == 0)
            return x;
        return (x << m) | (x >> (32 - m));
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    function automatic word_t iv_word(input logic [2:0] idx);
        word_t v;
        unique case (idx)
            3'd0: v = 32'h7380166F;
            3'd1: v = 32'h4914B2B9;
            3'd2: v = 32'h172442D7;
            3'd3: v = 32'hDA8A0600;
            3'd4: v = 32'hA96F30BC;
            3'd5: v = 32'h163138AA;
            3'd6: v = 32'hE38DEE4D;
            3'd7: v = 32'hB0FB0E4E;
        endcase
        return v;
    endfunction

    // keep the leading bytes of a short last word and append the 0x80 marker
    function automatic word_t pad_short(input word_t w, input logic [2:0] n);
        word_t v;
        unique case (n)
            3'd0: v = PAD_WORD;
            3'd1: v = {w[31:24], 8'h80, 16'h0000};
            3'd2: v = {w[31:16], 8'h80, 8'h00};
            3'd3: v = {w[31:8], 8'h80};
            default: v = w;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/sm3_round.sv @@
// one sm3 compression round plus one message expansion step
`timescale 1ns / 1ps

module sm3_round
    import sm3_pkg::*;
(
    input  word_t work_in [8],
    input  word_t w_j,
    input  word_t w_j3,
    input  word_t w_j4,
    input  word_t w_j7,
    input  word_t w_j10,
    input  word_t w_j13,
    input  word_t t_rot,
    input  logic  high,
    output word_t work_out [8],
    output word_t w_new
);

    word_t a12;
    word_t ss1;
    word_t ss2;
    word_t ff;
    word_t gg;
    word_t tt1;
    word_t tt2;

    always_comb
    begin
        a12 = rotl(work_in[0], 12);
        ss1 = rotl(a12 + work_in[4] + t_rot, 7);
        ss2 = ss1 ^ a12;
        if (high)
        begin
            ff = (work_in[0] & work_in[1]) | (work_in[0] & work_in[2])
                 | (work_in[1] & work_in[2]);
            gg = (work_in[4] & work_in[5]) | (~work_in[4] & work_in[6]);
        end
        else
        begin
            ff = work_in[0] ^ work_in[1] ^ work_in[2];
            gg = work_in[4] ^ work_in[5] ^ work_in[6];
        end
        tt1 = ff + work_in[3] + ss2 + (w_j ^ w_j4);
        tt2 = gg + work_in[7] + ss1 + w_j;

        work_out[0] = tt1;
        work_out[1] = work_in[0];
        work_out[2] = rotl(work_in[1], 9);
        work_out[3] = work_in[2];
        work_out[4] = perm0(tt2);
        work_out[5] = work_in[4];
        work_out[6] = rotl(work_in[5], 19);
        work_out[7] = work_in[6];

        w_new = perm1(w_j ^ w_j7 ^ rotl(w_j13, 15)) ^ rotl(w_j3, 7) ^ w_j10;
    end

endmodule

@@ rtl/core/sm3_hash.sv @@
// sm3 hash core: word intake, padding sequencer, round loop and digest output
//
// Message words enter one beat per cycle while the core is ready. Every
// sixteenth word starts a compression, one round per cycle on a single
// shared round unit, during which s_tready stays low. The beat with s_tlast
// set adds the padding words internally, one per cycle, followed by one or
// two more compressions, and then the eight digest words leave as eight m_
// beats, word 0 first, the last with m_tlast. The core then starts a fresh
// message.
`timescale 1ns / 1ps

module sm3_hash
    import sm3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [TdataW-1:0] s_tdata,   // message_word[31:0], byte_count[34:32], zero fill
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [TdataW-1:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic              m_tlast
);

    state_t      state_reg;
    state_t      state_next;
    logic [3:0]  fill_reg;
    logic [63:0] len_reg;
    logic        pad_active_reg;
    logic        need80_reg;
    logic        hi_done_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    word_t       t_reg;
    word_t       chain_reg [8];
    word_t       work_reg [8];
    word_t       win_reg [BlkWords];

    word_t       work_rnd [8];
    word_t       w_new;

    word_t       in_word;
    logic [2:0]  byte_count;
    logic [2:0]  n_clamp;
    logic        in_fire;
    logic        out_fire;
    logic        push_en;
    word_t       push_data;
    logic        block_full;
    logic        last_round;
    logic        out_end;

    assign in_word    = s_tdata[31:0];
    assign byte_count = s_tdata[34:32];
    assign n_clamp    = (byte_count > 3'd4) ? 3'd4 : byte_count;

    assign m_tdata = {5'b00000, idx_reg, chain_reg[0]};
    assign m_tlast = (idx_reg == 3'd7);

    sm3_round u_round (
        .work_in  (work_reg),
        .w_j      (win_reg[0]),
        .w_j3     (win_reg[3]),
        .w_j4     (win_reg[4]),
        .w_j7     (win_reg[7]),
        .w_j10    (win_reg[10]),
        .w_j13    (win_reg[13]),
        .t_rot    (t_reg),
        .high     (round_reg[5:4] != 2'b00),
        .work_out (work_rnd),
        .w_new    (w_new)
    );

    // handshakes and the word pushed into the block this cycle
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_OUT);
        in_fire   = s_tvalid && s_tready;
        out_fire  = m_tvalid && m_tready;
        push_en   = 1'b0;
        push_data = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    push_en = 1'b1;
                    if (!s_tlast || n_clamp == 3'd4)
                        push_data = in_word;
                    else
                        push_data = pad_short(in_word, n_clamp);
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                priority if (need80_reg)
                    push_data = PAD_WORD;
                else if (hi_done_reg)
                    push_data = len_reg[31:0];
                else if (fill_reg == 4'd14)
                    push_data = len_reg[63:32];
                else
                    push_data = '0;
            end
            ST_ROUND, ST_OUT:
            begin
                push_en = 1'b0;
            end
        endcase
        block_full = push_en && (fill_reg == 4'd15);
        last_round = (state_reg == ST_ROUND) && (round_reg == 6'd63);
        out_end    = out_fire && (idx_reg == 3'd7);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (block_full)
                        state_next = ST_ROUND;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (block_full)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (last_round)
                begin
                    // the length low word closes the final block
                    if (pad_active_reg && hi_done_reg)
                        state_next = ST_OUT;
                    else if (pad_active_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_end)
                    state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            len_reg        <= '0;
            pad_active_reg <= 1'b0;
            need80_reg     <= 1'b0;
            hi_done_reg    <= 1'b0;
            round_reg      <= '0;
            idx_reg        <= '0;
            for (int i = 0; i < DigWords; i++)
                chain_reg[i] <= iv_word(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (push_en)
                fill_reg <= fill_reg + 4'd1;
            if (in_fire)
            begin
                if (s_tlast)
                    len_reg <= len_reg + {58'd0, n_clamp, 3'b000};
                else
                    len_reg <= len_reg + 64'd32;
            end
            else if (out_end)
                len_reg <= '0;

            if (in_fire && s_tlast)
                pad_active_reg <= 1'b1;
            else if (out_end)
                pad_active_reg <= 1'b0;

            if (in_fire && s_tlast && n_clamp == 3'd4)
                need80_reg <= 1'b1;
            else if (state_reg == ST_PAD)
                need80_reg <= 1'b0;

            if (state_reg == ST_PAD && !need80_reg && !hi_done_reg && fill_reg == 4'd14)
                hi_done_reg <= 1'b1;
            else if (out_end)
                hi_done_reg <= 1'b0;

            if (state_reg == ST_ROUND)
                round_reg <= round_reg + 6'd1;

            if (out_fire)
                idx_reg <= idx_reg + 3'd1;

            // feed-forward at the end of a block, then refill with the iv while
            // the digest shifts out
            if (last_round)
            begin
                for (int i = 0; i < DigWords; i++)
                    chain_reg[i] <= chain_reg[i] ^ work_rnd[i];
            end
            else if (out_fire)
            begin
                for (int i = 0; i < DigWords - 1; i++)
                    chain_reg[i] <= chain_reg[i + 1];
                chain_reg[DigWords-1] <= iv_word(idx_reg);
            end
        end
    end

    // round registers, round constant and the block / expansion window
    always_ff @(posedge clk)
    begin
        if (block_full)
        begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= chain_reg[i];
            t_reg <= T_LOW;
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= work_rnd[i];
            if (round_reg == 6'd15)
                t_reg <= T_HIGH_R;
            else
                t_reg <= rotl(t_reg, 1);
        end

        if (push_en || state_reg == ST_ROUND)
        begin
            for (int i = 0; i < BlkWords - 1; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[BlkWords-1] <= push_en ? push_data : w_new;
        end
    end

endmodule

@@ rtl/core/sm3_hash_chk.sv @@
// port-level checker for the sm3 hash core, bound to the top level
`timescale 1ns / 1ps

module sm3_hash_chk
    import sm3_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [TdataW-1:0] m_tdata,
    input logic              m_tlast
);

    // no intake while the digest is going out
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while digest beats pending");

    // digest beats come back to back in index order
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("digest index out of sequence");

    // after the final digest beat the core takes a new message
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("core not ready after digest");

    // a word that is not last never produces a digest
    a_nolast: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tlast) |=> !m_tvalid)
        else $error("digest after a non-last word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled digest beat changed");

endmodule

bind sm3_hash sm3_hash_chk u_sm3_hash_chk (.*);

@@ dv/sm3_hash_tb.sv @@
// self-checking testbench for the sm3_hash core: message stream in, digest beats out
`timescale 1ns / 1ps

module sm3_hash_tb;

    import sm3_pkg::TdataW;

    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        last;
    } msg_beat_t;

    typedef struct {
        logic [31:0] digest;
        logic [2:0]  index;
        logic        done;
    } digest_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [TdataW-1:0] s_tdata = '0;   // message_word[31:0], byte_count[34:32], zero fill
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [TdataW-1:0] m_tdata;        // digest_word[31:0], word_index[34:32], zero fill
    logic              m_tlast;

    msg_beat_t    msg_q[$];
    digest_beat_t digest_q[$];

    // predictor state
    logic [31:0] chain[8];
    logic [31:0] blk_words[16];
    int          blk_fill;
    logic [63:0] msg_bits;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_errors = 0;
    int n_beats_in = 0;
    int n_digests_seen = 0;
    int n_messages = 0;

    logic hold_go = 1'b0;
    logic hold_spent = 1'b0;
    int   hold_ctr = 0;
    wire  hold_on = hold_go && !hold_spent;

    sm3_hash dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting for the core");
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        int m;
        m = n % 32;
        if (m == 0)
            return x;
        return (x << m) | (x >> (32 - m));
    endfunction

    function automatic logic [31:0] mix0(input logic [31:0] x);
        return x ^ rol(x, 9) ^ rol(x, 17);
    endfunction

    function automatic logic [31:0] mix1(input logic [31:0] x);
        return x ^ rol(x, 15) ^ rol(x, 23);
    endfunction

    function automatic void reset_chain();
        chain[0] = 32'h7380166F;
        chain[1] = 32'h4914B2B9;
        chain[2] = 32'h172442D7;
        chain[3] = 32'hDA8A0600;
        chain[4] = 32'hA96F30BC;
        chain[5] = 32'h163138AA;
        chain[6] = 32'hE38DEE4D;
        chain[7] = 32'hB0FB0E4E;
        blk_fill = 0;
        msg_bits = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w[16];
        logic [31:0] r[8];
        logic [31:0] wj, a12, ss1, ss2, ff, gg, t1, t2, tj, wn;
        for (int i = 0; i < 16; i++)
            w[i] = blk_words[i];
        for (int i = 0; i < 8; i++)
            r[i] = chain[i];
        for (int j = 0; j < 64; j++)
        begin
            wj  = w[j % 16];
            tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
            a12 = rol(r[0], 12);
            ss1 = rol(a12 + r[4] + rol(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ff = r[0] ^ r[1] ^ r[2];
                gg = r[4] ^ r[5] ^ r[6];
            end
            else
            begin
                ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                gg = (r[4] & r[5]) | (~r[4] & r[6]);
            end
            t1 = ff + r[3] + ss2 + (wj ^ w[(j + 4) % 16]);
            t2 = gg + r[7] + ss1 + wj;
            r[3] = r[2]; r[2] = rol(r[1], 9);  r[1] = r[0]; r[0] = t1;
            r[7] = r[6]; r[6] = rol(r[5], 19); r[5] = r[4]; r[4] = mix0(t2);
            // expanded word j+16 takes the slot of word j
            wn = mix1(wj ^ w[(j + 7) % 16] ^ rol(w[(j + 13) % 16], 15))
                 ^ rol(w[(j + 3) % 16], 7) ^ w[(j + 10) % 16];
            w[j % 16] = wn;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] ^ r[i];
    endfunction

    function automatic void absorb_word(input logic [31:0] w);
        blk_words[blk_fill] = w;
        blk_fill++;
        if (blk_fill == 16)
        begin
            compress_block();
            blk_fill = 0;
        end
    endfunction

    // one accepted input beat; on the last beat pad, finish and queue the digest
    function automatic void hash_beat(input logic [31:0] w, input logic [2:0] nb,
                                      input logic last);
        int          nv;
        logic [31:0] mask;
        digest_beat_t d;
        if (!last)
        begin
            absorb_word(w);
            msg_bits += 64'd32;
            return;
        end
        nv = (nb > 3'd4) ? 4 : int'(nb);
        msg_bits += 64'(8 * nv);
        if (nv == 4)
        begin
            absorb_word(w);
            absorb_word(32'h80000000);
        end
        else
        begin
            mask = (nv == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * nv));
            absorb_word((w & mask) | (32'h80 << (24 - 8 * nv)));
        end
        while (blk_fill != 14)
            absorb_word(32'h0);
        absorb_word(msg_bits[63:32]);
        absorb_word(msg_bits[31:0]);
        for (int k = 0; k < 8; k++)
        begin
            d.digest = chain[k];
            d.index  = 3'(k);
            d.done   = (k == 7);
            digest_q.push_back(d);
        end
        n_messages++;
        reset_chain();
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t ns", what, got, want, $realtime);
        n_errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drive_msg
        msg_beat_t b;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                hash_beat(s_tdata[31:0], s_tdata[34:32], s_tlast);
                n_beats_in++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (msg_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    b = msg_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(TdataW - 35){1'b0}}, b.nbytes, b.word};
                    s_tlast  <= b.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : watch_digest
        digest_beat_t d;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_digests_seen++;
                if (digest_q.size() == 0)
                    report_mismatch("unexpected digest beat", m_tdata[31:0], 32'h0);
                else
                begin
                    d = digest_q.pop_front();
                    if (m_tdata[31:0] !== d.digest)
                        report_mismatch("digest_word", m_tdata[31:0], d.digest);
                    if (m_tdata[34:32] !== d.index)
                        report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(d.index));
                    if (m_tlast !== d.done)
                        report_mismatch("digest_done", 32'(m_tlast), 32'(d.done));
                end
            end
            m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ctr   <= 0;
            hold_spent <= 1'b0;
        end
        else if (hold_go && !hold_spent)
        begin
            if (hold_ctr == HOLD_CYCLES)
                hold_spent <= 1'b1;
            else
                hold_ctr <= hold_ctr + 1;
        end
    end

    task automatic push_beat(input logic [31:0] w, input logic [2:0] nb, input logic last);
        msg_beat_t b;
        b.word   = w;
        b.nbytes = nb;
        b.last   = last;
        msg_q.push_back(b);
    endtask

    // random message: mostly short, now and then long enough for several blocks
    task automatic push_random_message(output int nw);
        logic [31:0] w;
        nw = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
        for (int i = 0; i < nw; i++)
        begin
            case ($urandom_range(9))
                0: w = 32'h0;
                1: w = 32'hFFFFFFFF;
                default: w = $urandom;
            endcase
            push_beat(w, 3'($urandom_range(7)), i == nw - 1);
        end
    endtask

    task automatic random_phase(input int n_items);
        int total, nw;
        total = 0;
        while (total < n_items)
        begin
            push_random_message(nw);
            total += nw;
        end
    endtask

    task automatic wait_drained();
        while (msg_q.size() != 0 || s_tvalid || digest_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        reset_chain();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty message, every byte count, short words not last,
        // extremes of the word, and a last word that pushes the padding into a second block
        push_beat(32'h0, 3'd0, 1'b1);
        push_beat(32'hFFFFFFFF, 3'd1, 1'b1);
        push_beat(32'hFFFFFFFF, 3'd2, 1'b1);
        push_beat(32'h61626300, 3'd3, 1'b1);
        push_beat(32'hFFFFFFFF, 3'd4, 1'b1);
        push_beat(32'h0, 3'd4, 1'b1);
        push_beat(32'h12345678, 3'd5, 1'b1);
        push_beat(32'hA5A5A5A5, 3'd6, 1'b1);
        push_beat(32'hFFFFFFFF, 3'd7, 1'b1);
        push_beat(32'hFFFFFFFF, 3'd1, 1'b0);
        push_beat(32'h0, 3'd0, 1'b1);
        for (int i = 0; i < 13; i++)
            push_beat(32'hFFFFFFFF ^ 32'(i), 3'(i), 1'b0);
        push_beat(32'hFFFFFFFF, 3'd4, 1'b1);
        random_phase(40);
        wait_drained();

        send_idle_pct = 68;
        @(negedge clk);
        random_phase(40);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 68;
        @(negedge clk);
        random_phase(40);
        wait_drained();

        send_idle_pct  = 6;
        recv_stall_pct = 6;
        @(negedge clk);
        random_phase(40);
        wait_drained();

        // output held off while several messages queue up behind it
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        random_phase(40);
        @(posedge clk);
        hold_go <= 1'b1;
        wait_drained();

        repeat (200) @(posedge clk);
        if (digest_q.size() != 0)
        begin
            $display("%0d digest beats never arrived", digest_q.size());
            n_errors++;
        end
        $display("covered %0d message beats in %0d messages, %0d digest beats checked",
                 n_beats_in, n_messages, n_digests_seen);
        $display("phases: back to back, sender gaps, receiver stalls, both, long hold-off");
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sm3_pkg.sv
rtl/core/sm3_round.sv
rtl/core/sm3_hash.sv
rtl/core/sm3_hash_chk.sv
dv/sm3_hash_tb.sv
